// ===== hw/rtl/ranked_top_k_insert_defines.svh =====
// Assertion macros shared by the ranked table RTL.
`ifndef RANKED_TOP_K_INSERT_DEFINES_SVH
`define RANKED_TOP_K_INSERT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RTKI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtki same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RTKI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtki next-cycle check failed");

`endif

// ===== hw/rtl/rtki_pkg.sv =====
// Types and constants shared by the ranked table controller and datapath.
package rtki_pkg;

    localparam int KILL_W  = 16;
    localparam int TIME_W  = 32;
    localparam int STAMP_W = 63;
    localparam int RANK_W  = 5;
    localparam int IDX_W   = 4;
    localparam int LIM_W   = 5;
    localparam int OP_W    = 2;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd10;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [KILL_W-1:0]  kills;
        logic [TIME_W-1:0]  ptime;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;   // capture the item, issue the first read
        logic scan;    // compare one entry, shift it down if it ranks after
        logic place;   // write the new entry, update count and rank
        logic finish;  // load the result register
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic item_gt;   // held entry under compare ranks after the new item
        logic cur_zero;  // compare index has reached the top of the table
    } t_stat;

endpackage

// ===== hw/rtl/rtki_ctrl.sv =====
// Sequencer for the ranked table: handshakes and walk control.
`include "ranked_top_k_insert_defines.svh"

module rtki_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [rtki_pkg::OP_W-1:0]   i_opcode,
    output logic                        o_valid,
    input  logic                        i_stall,
    output rtki_pkg::t_cmd              o_cmd,
    input  rtki_pkg::t_stat             i_stat
);

    rtki_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rtki_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            rtki_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_opcode == rtki_pkg::OP_INSERT) begin
                        n_state = i_stat.count_zero ? rtki_pkg::ST_PLACE
                                                    : rtki_pkg::ST_SCAN;
                    end else begin
                        n_state = rtki_pkg::ST_DONE;
                    end
                end
            end
            rtki_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (!i_stat.item_gt || i_stat.cur_zero) begin
                    n_state = rtki_pkg::ST_PLACE;
                end
            end
            rtki_pkg::ST_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = rtki_pkg::ST_DONE;
            end
            rtki_pkg::ST_DONE: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = rtki_pkg::ST_IDLE;
                end
            end
            default: n_state = rtki_pkg::ST_IDLE;
        endcase
        n_out_valid = o_cmd.finish ? 1'b1 : (r_out_valid && i_stall);
    end

    `RTKI_ASSERT_NEXT(a_ins_walks,
        i_valid && !o_stall && i_opcode == rtki_pkg::OP_INSERT && !i_stat.count_zero,
        r_state == rtki_pkg::ST_SCAN)
    `RTKI_ASSERT_NEXT(a_place_done, r_state == rtki_pkg::ST_PLACE,
        r_state == rtki_pkg::ST_DONE)
    `RTKI_ASSERT_NEXT(a_done_out, r_state == rtki_pkg::ST_DONE && out_free,
        r_state == rtki_pkg::ST_IDLE && r_out_valid)

endmodule

// ===== hw/rtl/rtki_dp.sv =====
// Ranked table datapath: entry memory, item registers, compare and result register.
`include "ranked_top_k_insert_defines.svh"

module rtki_dp #(
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_score_limit_we,
    input  logic [rtki_pkg::LIM_W-1:0]      i_score_limit,
    input  logic [rtki_pkg::OP_W-1:0]       i_opcode,
    input  logic [rtki_pkg::KILL_W-1:0]     i_kill_count,
    input  logic [rtki_pkg::TIME_W-1:0]     i_play_time,
    input  logic [rtki_pkg::STAMP_W-1:0]    i_stamp,
    input  logic [rtki_pkg::IDX_W-1:0]      i_read_index,
    input  rtki_pkg::t_cmd                  i_cmd,
    output rtki_pkg::t_stat                 o_stat,
    output logic [rtki_pkg::RANK_W-1:0]     o_rank,
    output logic                            o_entry_valid,
    output logic [rtki_pkg::KILL_W-1:0]     o_entry_kills,
    output logic [rtki_pkg::TIME_W-1:0]     o_entry_time,
    output logic [rtki_pkg::STAMP_W-1:0]    o_entry_stamp,
    output logic [rtki_pkg::RANK_W-1:0]     o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > rtki_pkg::LIM_W) ? CW : rtki_pkg::LIM_W;

    rtki_pkg::t_entry mem [DEPTH];
    rtki_pkg::t_entry r_rd;
    rtki_pkg::t_entry item;

    logic [rtki_pkg::LIM_W-1:0]  r_limit;
    logic [CW-1:0]               r_count;
    logic [rtki_pkg::OP_W-1:0]   r_op;
    logic [rtki_pkg::KILL_W-1:0] r_kills;
    logic [rtki_pkg::TIME_W-1:0] r_time;
    logic [rtki_pkg::STAMP_W-1:0] r_stamp;
    logic [rtki_pkg::IDX_W-1:0]  r_ridx;
    logic [AW-1:0]               r_cur;
    logic [CW-1:0]               r_pos;
    logic [CW-1:0]               r_rank;

    logic [XW-1:0]  limit_x;
    logic [CW-1:0]  lim;
    logic [CW-1:0]  cur_next;
    logic [CW:0]    count_inc;
    logic           gt;
    logic           rd_valid;
    logic           mem_we, rd_en;
    logic [AW-1:0]  wr_addr, rd_addr;
    rtki_pkg::t_entry wr_data;

    assign limit_x = XW'(r_limit);

    // Limit clamped to 1..DEPTH.
    always_comb begin
        if (r_limit == '0) begin
            lim = CW'(1);
        end else if (limit_x > XW'(DEPTH)) begin
            lim = CW'(DEPTH);
        end else begin
            lim = CW'(limit_x);
        end
    end

    assign item     = '{kills: r_kills, ptime: r_time, stamp: r_stamp};
    assign cur_next = CW'(r_cur) + CW'(1);
    assign count_inc = (CW+1)'(r_count) + (CW+1)'(1);
    assign gt = (r_kills < r_rd.kills) ||
                (r_kills == r_rd.kills && r_time < r_rd.ptime);
    assign rd_valid = (r_op == rtki_pkg::OP_READ) && (XW'(r_ridx) < XW'(r_count));

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.item_gt    = gt;
    assign o_stat.cur_zero   = (r_cur == '0);

    // Walk runs bottom up: each entry that ranks after the item moves down one
    // slot, but only below the limit so a rejected insert leaves the table intact.
    always_comb begin
        mem_we  = 1'b0;
        wr_addr = r_cur;
        wr_data = r_rd;
        rd_en   = 1'b0;
        rd_addr = r_cur;
        if (i_cmd.start) begin
            if (i_opcode == rtki_pkg::OP_INSERT) begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_count - CW'(1));
            end else if (i_opcode == rtki_pkg::OP_READ) begin
                rd_en   = 1'b1;
                rd_addr = AW'(XW'(i_read_index));
            end
        end
        if (i_cmd.scan && gt) begin
            mem_we  = (cur_next < lim);
            wr_addr = AW'(cur_next);
            if (r_cur != '0) begin
                rd_en   = 1'b1;
                rd_addr = r_cur - AW'(1);
            end
        end
        if (i_cmd.place && r_pos < lim) begin
            mem_we  = 1'b1;
            wr_addr = AW'(r_pos);
            wr_data = item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= rtki_pkg::LIMIT_RESET;
            r_count <= '0;
        end else begin
            if (i_score_limit_we) begin
                r_limit <= i_score_limit;
            end
            if (i_cmd.start && i_opcode == rtki_pkg::OP_CLEAR) begin
                r_count <= '0;
            end
            if (i_cmd.place && r_pos < lim) begin
                r_count <= (count_inc > (CW+1)'(lim)) ? lim : CW'(count_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_opcode;
            r_kills <= i_kill_count;
            r_time  <= i_play_time;
            r_stamp <= i_stamp;
            r_ridx  <= i_read_index;
            r_cur   <= AW'(r_count - CW'(1));
            r_pos   <= r_count;
            r_rank  <= '0;
        end
        if (i_cmd.scan) begin
            if (!gt) begin
                r_pos <= cur_next;
            end else if (r_cur == '0) begin
                r_pos <= '0;
            end else begin
                r_cur <= r_cur - AW'(1);
            end
        end
        if (i_cmd.place && r_pos < lim) begin
            r_rank <= r_pos + CW'(1);
        end
        if (i_cmd.finish) begin
            o_rank        <= rtki_pkg::RANK_W'(r_rank);
            o_entry_valid <= rd_valid;
            o_entry_kills <= rd_valid ? r_rd.kills : '0;
            o_entry_time  <= rd_valid ? r_rd.ptime : '0;
            o_entry_stamp <= rd_valid ? r_rd.stamp : '0;
            o_entry_count <= rtki_pkg::RANK_W'(r_count);
        end
    end

    `RTKI_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CW'(DEPTH))
    `RTKI_ASSERT_NOW(a_limit_range, 1'b1, lim != '0 && lim <= CW'(DEPTH))
    `RTKI_ASSERT_NEXT(a_place_rank, i_cmd.place && r_pos < lim, r_rank != '0)

endmodule

// ===== hw/rtl/ranked_top_k_insert.sv =====
// Ranked top-k table: insert before the first worse entry, read one entry, clear.
// Read, clear and unused items go from idle straight to the result; an insert walks
// bottom up, moving one held entry per cycle through the entry memory, then places
// the item. A new beat is taken only in idle, after the result loads; a stalled
// result holds input.
// Synchronous reset: table empty, score_limit 10; entry memory is not cleared.
module ranked_top_k_insert #(
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_score_limit_we,
    input  logic [rtki_pkg::LIM_W-1:0]      i_score_limit,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rtki_pkg::OP_W-1:0]       i_opcode,
    input  logic [rtki_pkg::KILL_W-1:0]     i_kill_count,
    input  logic [rtki_pkg::TIME_W-1:0]     i_play_time,
    input  logic [rtki_pkg::STAMP_W-1:0]    i_stamp,
    input  logic [rtki_pkg::IDX_W-1:0]      i_read_index,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rtki_pkg::RANK_W-1:0]     o_rank,
    output logic                            o_entry_valid,
    output logic [rtki_pkg::KILL_W-1:0]     o_entry_kills,
    output logic [rtki_pkg::TIME_W-1:0]     o_entry_time,
    output logic [rtki_pkg::STAMP_W-1:0]    o_entry_stamp,
    output logic [rtki_pkg::RANK_W-1:0]     o_entry_count
);

    rtki_pkg::t_cmd  cmd;
    rtki_pkg::t_stat stat;

    rtki_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_opcode (i_opcode),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    rtki_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_score_limit_we (i_score_limit_we),
        .i_score_limit    (i_score_limit),
        .i_opcode         (i_opcode),
        .i_kill_count     (i_kill_count),
        .i_play_time      (i_play_time),
        .i_stamp          (i_stamp),
        .i_read_index     (i_read_index),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_rank           (o_rank),
        .o_entry_valid    (o_entry_valid),
        .o_entry_kills    (o_entry_kills),
        .o_entry_time     (o_entry_time),
        .o_entry_stamp    (o_entry_stamp),
        .o_entry_count    (o_entry_count)
    );

endmodule
